/* hw/rtl/sfd_pkg.sv */
// Shared types, constants and the CRC-16 byte update for the sync frame deframer.
package sfd_pkg;

    localparam int BUFFER_DEPTH_DEF = 64;

    localparam int LEN_W     = 6;
    localparam int LIM_W     = 7;
    localparam int CFG_IDX_W = 2;
    localparam int WIN_DEPTH = 5;

    localparam logic [CFG_IDX_W-1:0] CFG_SYNC_FIRST  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SYNC_SECOND = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_VERSION     = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_PAYLOAD = 2'd3;

    localparam logic [7:0]       SYNC_FIRST_RST  = 8'hAA;
    localparam logic [7:0]       SYNC_SECOND_RST = 8'h55;
    localparam logic [7:0]       VERSION_RST     = 8'h01;
    localparam logic [LEN_W-1:0] MAX_PAYLOAD_RST = 6'd32;

    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [15:0] CRC_POLY = 16'h1021;

    typedef struct packed {
        logic                    hit;
        logic [7:0]              version;
        logic [7:0]              ftype;
        logic [LEN_W-1:0]        len;
    } t_hdr_hit;

    typedef struct packed {
        logic [WIN_DEPTH-1:0][7:0] w;
        logic [2:0]                fill;
    } t_win;

    function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {b, 8'h00};
        for (int k = 0; k < 8; k++) begin
            if (c[15]) begin
                c = {c[14:0], 1'b0} ^ CRC_POLY;
            end else begin
                c = {c[14:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage

/* hw/rtl/sync_frame_deframer_crc16_top.sv */
// Top level of the sync/length framed packet deframer with CRC-16 check.
//
// Input: one received byte per word on s_axis. Output: one word per payload byte of each
// frame whose CRC-16 (poly 0x1021, init 0xFFFF) over version, type, length and payload
// matches the little-endian CRC that follows it; an empty frame gives a single word with
// byte_valid low. Frames with a bad CRC produce nothing.
// Hunting, payload and CRC bytes are taken one per cycle. After a header is found the
// input holds off while the header CRC runs over version, type and length, one byte per
// cycle. After a good CRC the input holds off while the payload memory is read back, one
// word per cycle when the receiver keeps m_axis_tready high. The read port of the
// payload memory sets this rate; output words appear in the cycle after the memory read
// is issued. The output register holds a finished word while the receiver stalls; once a
// frame's last word is issued, input bytes keep being accepted meanwhile until the next
// drain begins. Configuration is written through i_cfg_we, i_cfg_idx and i_cfg_data; the
// user must write it only while idle; the block itself does not enforce it. Synchronous
// active-low reset empties the header window, returns to hunting, restores the register
// defaults and clears the output valid. The payload memory needs no clearing.
module sync_frame_deframer_crc16_top #(
    parameter int BUFFER_DEPTH = sfd_pkg::BUFFER_DEPTH_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [sfd_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [7:0]                    i_cfg_data,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    input  logic [7:0]                    s_axis_tdata,  // [7:0] data_byte
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    // [7:0] frame_type, [13:8] payload_len, [21:14] payload_byte, [27:22] byte_index
    output logic [31:0]                   m_axis_tdata,
    output logic                          m_axis_tlast,
    output logic [0:0]                    m_axis_tuser   // [0] byte_valid
);

    localparam int AW = $clog2(BUFFER_DEPTH);
    localparam logic [sfd_pkg::LIM_W-1:0] DEPTH_LIM = sfd_pkg::LIM_W'(BUFFER_DEPTH);

    typedef enum logic [5:0] {
        S_HUNT  = 6'b000001,
        S_HDR   = 6'b000010,
        S_PAY   = 6'b000100,
        S_CRCL  = 6'b001000,
        S_CRCH  = 6'b010000,
        S_DRAIN = 6'b100000
    } t_state;

    logic [7:0]                r_sync_first;
    logic [7:0]                r_sync_second;
    logic [7:0]                r_version;
    logic [sfd_pkg::LEN_W-1:0] r_max_payload;

    t_state                    r_state;
    t_state                    n_state;
    logic [2:0][7:0]           r_hdr;
    logic [2:0][7:0]           n_hdr;
    logic [1:0]                r_hdr_cnt;
    logic [1:0]                n_hdr_cnt;
    logic [7:0]                r_type;
    logic [7:0]                n_type;
    logic [sfd_pkg::LEN_W-1:0] r_len;
    logic [sfd_pkg::LEN_W-1:0] n_len;
    logic [sfd_pkg::LEN_W-1:0] r_cnt;
    logic [sfd_pkg::LEN_W-1:0] n_cnt;
    logic [sfd_pkg::LEN_W-1:0] r_idx;
    logic [sfd_pkg::LEN_W-1:0] n_idx;
    logic [15:0]               r_crc;
    logic [15:0]               n_crc;
    logic [7:0]                r_crc_low;
    logic [7:0]                n_crc_low;

    logic                      r_out_valid;
    logic                      n_out_valid;
    logic [7:0]                r_out_type;
    logic [sfd_pkg::LEN_W-1:0] r_out_len;
    logic [sfd_pkg::LEN_W-1:0] r_out_index;
    logic                      r_out_bvalid;
    logic                      r_out_last;

    logic [sfd_pkg::LIM_W-1:0] w_limit;
    logic                      in_fire;
    logic                      issue;
    logic                      w_last;
    logic                      wr_en;
    logic                      rd_en;
    logic [7:0]                rd_data;
    logic [sfd_pkg::LEN_W-1:0] cnt_inc;
    sfd_pkg::t_hdr_hit         hit;

    assign w_limit = ({1'b0, r_max_payload} < DEPTH_LIM) ? {1'b0, r_max_payload} : DEPTH_LIM;

    assign s_axis_tready = (r_state == S_HUNT) || (r_state == S_PAY)
                           || (r_state == S_CRCL) || (r_state == S_CRCH);
    assign in_fire = s_axis_tvalid && s_axis_tready;
    assign issue   = (r_state == S_DRAIN) && (!r_out_valid || m_axis_tready);
    assign w_last  = (r_len == '0) || ((r_idx + 6'd1) == r_len);
    assign wr_en   = in_fire && (r_state == S_PAY);
    assign rd_en   = issue && (r_len != '0);
    assign cnt_inc = r_cnt + 6'd1;

    sfd_hunter u_hunter (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_byte_en     (in_fire && (r_state == S_HUNT)),
        .i_byte        (s_axis_tdata),
        .i_sync_first  (r_sync_first),
        .i_sync_second (r_sync_second),
        .i_version     (r_version),
        .i_limit       (w_limit),
        .o_hit         (hit)
    );

    sfd_payload_ram #(
        .DEPTH (BUFFER_DEPTH)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (r_cnt[AW-1:0]),
        .i_wr_data (s_axis_tdata),
        .i_rd_en   (rd_en),
        .i_rd_addr (r_idx[AW-1:0]),
        .o_rd_data (rd_data)
    );

    always_comb begin
        n_state     = r_state;
        n_hdr       = r_hdr;
        n_hdr_cnt   = r_hdr_cnt;
        n_type      = r_type;
        n_len       = r_len;
        n_cnt       = r_cnt;
        n_idx       = r_idx;
        n_crc       = r_crc;
        n_crc_low   = r_crc_low;
        n_out_valid = r_out_valid;
        if (r_out_valid && m_axis_tready) begin
            n_out_valid = 1'b0;
        end
        case (r_state)
            S_HUNT: begin
                if (hit.hit) begin
                    n_hdr     = {{2'b00, hit.len}, hit.ftype, hit.version};
                    n_hdr_cnt = 2'd0;
                    n_type    = hit.ftype;
                    n_len     = hit.len;
                    n_cnt     = '0;
                    n_crc     = sfd_pkg::CRC_INIT;
                    n_state   = S_HDR;
                end
            end
            S_HDR: begin
                n_crc     = sfd_pkg::crc16_byte(r_crc, r_hdr[0]);
                n_hdr     = r_hdr >> 8;
                n_hdr_cnt = r_hdr_cnt + 2'd1;
                if (r_hdr_cnt == 2'd2) begin
                    n_state = (r_len == '0) ? S_CRCL : S_PAY;
                end
            end
            S_PAY: begin
                if (in_fire) begin
                    n_crc = sfd_pkg::crc16_byte(r_crc, s_axis_tdata);
                    n_cnt = cnt_inc;
                    if (cnt_inc >= r_len) begin
                        n_state = S_CRCL;
                    end
                end
            end
            S_CRCL: begin
                if (in_fire) begin
                    n_crc_low = s_axis_tdata;
                    n_state   = S_CRCH;
                end
            end
            S_CRCH: begin
                if (in_fire) begin
                    n_cnt = '0;
                    n_idx = '0;
                    if ({s_axis_tdata, r_crc_low} == r_crc) begin
                        n_state = S_DRAIN;
                    end else begin
                        n_state = S_HUNT;
                    end
                end
            end
            S_DRAIN: begin
                if (issue) begin
                    n_out_valid = 1'b1;
                    n_idx       = r_idx + 6'd1;
                    if (w_last) begin
                        n_state = S_HUNT;
                    end
                end
            end
            default: begin
                n_state = S_HUNT;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_HUNT;
            r_out_valid   <= 1'b0;
            r_sync_first  <= sfd_pkg::SYNC_FIRST_RST;
            r_sync_second <= sfd_pkg::SYNC_SECOND_RST;
            r_version     <= sfd_pkg::VERSION_RST;
            r_max_payload <= sfd_pkg::MAX_PAYLOAD_RST;
            r_cnt         <= '0;
            r_idx         <= '0;
            r_hdr_cnt     <= 2'd0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            r_cnt       <= n_cnt;
            r_idx       <= n_idx;
            r_hdr_cnt   <= n_hdr_cnt;
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    sfd_pkg::CFG_SYNC_FIRST:  r_sync_first  <= i_cfg_data;
                    sfd_pkg::CFG_SYNC_SECOND: r_sync_second <= i_cfg_data;
                    sfd_pkg::CFG_VERSION:     r_version     <= i_cfg_data;
                    sfd_pkg::CFG_MAX_PAYLOAD: r_max_payload <= i_cfg_data[sfd_pkg::LEN_W-1:0];
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_hdr     <= n_hdr;
        r_type    <= n_type;
        r_len     <= n_len;
        r_crc     <= n_crc;
        r_crc_low <= n_crc_low;
        if (issue) begin
            r_out_type   <= r_type;
            r_out_len    <= r_len;
            r_out_index  <= (r_len == '0) ? '0 : r_idx;
            r_out_bvalid <= (r_len != '0);
            r_out_last   <= w_last;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {4'b0000, r_out_index, (r_out_bvalid ? rd_data : 8'h00),
                            r_out_len, r_out_type};
    assign m_axis_tlast  = r_out_last;
    assign m_axis_tuser  = r_out_bvalid;

    a_no_rw_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(wr_en && rd_en))
        else $error("payload memory written and read in the same cycle");

    a_index_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser[0] |-> (r_out_index < r_out_len))
        else $error("output byte index beyond payload length");

    a_empty_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tuser[0] |-> m_axis_tlast && (r_out_len == '0))
        else $error("empty-frame word is malformed");

    a_drain_entry: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DRAIN) && ($past(r_state) != S_DRAIN) |-> $past(r_state) == S_CRCH)
        else $error("readout started without a CRC check");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_PAY) |-> (r_cnt < r_len))
        else $error("payload count reached length while still storing");

endmodule

/* hw/rtl/sfd_payload_ram.sv */
// Single-port-per-direction payload memory with a registered read port.
module sfd_payload_ram #(
    parameter int DEPTH = sfd_pkg::BUFFER_DEPTH_DEF,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic          i_clk,
    input  logic          i_wr_en,
    input  logic [AW-1:0] i_wr_addr,
    input  logic [7:0]    i_wr_data,
    input  logic          i_rd_en,
    input  logic [AW-1:0] i_rd_addr,
    output logic [7:0]    o_rd_data
);

    logic [7:0] r_mem [DEPTH];
    logic [7:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

/* hw/rtl/sfd_hunter.sv */
// Five-byte sliding header window that hunts for sync pair, version and length.
module sfd_hunter (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_byte_en,
    input  logic [7:0]                    i_byte,
    input  logic [7:0]                    i_sync_first,
    input  logic [7:0]                    i_sync_second,
    input  logic [7:0]                    i_version,
    input  logic [sfd_pkg::LIM_W-1:0]     i_limit,
    output sfd_pkg::t_hdr_hit             o_hit
);

    logic [sfd_pkg::WIN_DEPTH-1:0][7:0] r_win;
    logic [2:0]                         r_fill;
    logic [sfd_pkg::WIN_DEPTH-1:0][7:0] n_win;
    logic [2:0]                         n_fill;

    sfd_pkg::t_win s0;
    sfd_pkg::t_win s1;
    sfd_pkg::t_win s2;
    sfd_pkg::t_win s3;
    logic          good_hdr;

    // One scan: cut window to first sync pair, else keep a trailing first byte or empty it.
    function automatic sfd_pkg::t_win scan(input sfd_pkg::t_win s, input logic [7:0] sf,
                                           input logic [7:0] ss);
        sfd_pkg::t_win r;
        logic          found;
        logic [2:0]    pos;
        logic [7:0]    tail;
        r     = s;
        found = 1'b0;
        pos   = 3'd0;
        tail  = 8'h00;
        for (int i = sfd_pkg::WIN_DEPTH - 2; i >= 0; i--) begin
            if ((i + 1) < int'(s.fill) && s.w[i] == sf && s.w[i+1] == ss) begin
                found = 1'b1;
                pos   = 3'(i);
            end
        end
        for (int k = 0; k < sfd_pkg::WIN_DEPTH; k++) begin
            if (k + 1 == int'(s.fill)) begin
                tail = s.w[k];
            end
        end
        if (s.fill >= 3'd2) begin
            if (found) begin
                r.w    = s.w >> (8 * pos);
                r.fill = s.fill - pos;
            end else if (tail == sf) begin
                r.w[0] = sf;
                r.fill = 3'd1;
            end else begin
                r.fill = 3'd0;
            end
        end
        return r;
    endfunction

    always_comb begin
        s0.w    = r_win;
        s0.fill = r_fill + 3'd1;
        for (int k = 0; k < sfd_pkg::WIN_DEPTH; k++) begin
            if (k == int'(r_fill)) begin
                s0.w[k] = i_byte;
            end
        end
        s1       = scan(s0, i_sync_first, i_sync_second);
        good_hdr = (s1.fill == 3'd5) && (s1.w[2] == i_version)
                   && (s1.w[4] <= {1'b0, i_limit});
        s2.w     = s1.w >> 8;
        s2.fill  = 3'd4;
        s3       = scan(s2, i_sync_first, i_sync_second);

        o_hit.hit     = i_byte_en && good_hdr;
        o_hit.version = s1.w[2];
        o_hit.ftype   = s1.w[3];
        o_hit.len     = s1.w[4][sfd_pkg::LEN_W-1:0];

        n_win  = r_win;
        n_fill = r_fill;
        if (i_byte_en) begin
            if (s1.fill != 3'd5) begin
                n_win  = s1.w;
                n_fill = s1.fill;
            end else if (good_hdr) begin
                n_fill = 3'd0;
            end else begin
                n_win  = s3.w;
                n_fill = s3.fill;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill <= 3'd0;
        end else begin
            r_fill <= n_fill;
        end
    end

    always_ff @(posedge i_clk) begin
        r_win <= n_win;
    end

endmodule
